>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the unfold engine checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IUE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication
`define IUE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/iue_pkg.sv
// ----------------------------------------------------------------------------
// iue_pkg
// shared types and constants of the im2col unfold engine
// ----------------------------------------------------------------------------
package iue_pkg;

   localparam int SEG_LIMIT = 64;

   localparam int DIV_DW = 12;
   localparam int DIV_VW = 10;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam logic [2:0] CFG_KERNEL_WIDTH  = 3'd0;
   localparam logic [2:0] CFG_KERNEL_HEIGHT = 3'd1;
   localparam logic [2:0] CFG_STRIDE_X      = 3'd2;
   localparam logic [2:0] CFG_STRIDE_Y      = 3'd3;
   localparam logic [2:0] CFG_PAD_X         = 3'd4;
   localparam logic [2:0] CFG_PAD_Y         = 3'd5;
   localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd6;
   localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd7;

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_VW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_DW-1:0] quot;
      logic [DIV_VW-1:0] rem;
   } div_rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIVW   = 8'b0000_0010,
      ST_DIVH   = 8'b0000_0100,
      ST_CHECK  = 8'b0000_1000,
      ST_DIVK   = 8'b0001_0000,
      ST_DIVR   = 8'b0010_0000,
      ST_ROW    = 8'b0100_0000,
      ST_STREAM = 8'b1000_0000
   } state_type;

endpackage

>>> rtl/iue_div.sv
// ----------------------------------------------------------------------------
// iue_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module iue_div
   import iue_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CW = $clog2(DIV_DW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIV_DW-1:0] quot_ff, quot_in;
   logic [DIV_VW-1:0] rem_ff, rem_in;
   logic [DIV_VW-1:0] divr_ff, divr_in;
   logic [DIV_VW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      divr_in = divr_ff;
      trial   = {rem_ff, quot_ff[DIV_DW-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_DW - 1);
         quot_in = div_req.dividend;
         rem_in  = '0;
         divr_in = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divr_ff}) begin
            rem_in  = DIV_VW'(trial - {1'b0, divr_ff});
            quot_in = {quot_ff[DIV_DW-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_VW-1:0];
            quot_in = {quot_ff[DIV_DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      divr_ff <= divr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

>>> rtl/iue_store.sv
// ----------------------------------------------------------------------------
// iue_store
// byte frame store, one write and one registered read port
// ----------------------------------------------------------------------------
module iue_store
   import iue_pkg::*;
#(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/im2col_unfold_engine.sv
// ----------------------------------------------------------------------------
// im2col_unfold_engine
// byte im2col unfolding with padding and stride over a plane/row/column store
// ----------------------------------------------------------------------------
// load beats: one per cycle while the engine is idle, written to the frame store at the accept edge
// emit beats: four serial divisions on the shared divider (ST_DIVW, ST_DIVH,
//   ST_DIVK, ST_DIVR), then one store read per in-bounds output column; one
//   result per cycle from the first result to the last column
// errors: static check errors in the cycle after accept, range errors out of ST_CHECK
// synchronous reset restores state, result and config defaults; frame store is not cleared
// ----------------------------------------------------------------------------
module im2col_unfold_engine
   import iue_pkg::*;
#(
   parameter int MAX_PLANES = 16,
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [3:0]  req_plane,
   input  logic [5:0]  req_pix_row,
   input  logic [5:0]  req_pix_col,
   input  logic [7:0]  req_pixel,
   input  logic [11:0] req_unfold_row,
   input  logic [5:0]  req_out_row,
   output logic        rsp_valid,
   output logic [7:0]  rsp_value,
   output logic [5:0]  rsp_out_col,
   output logic        rsp_last,
   output logic        rsp_error,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int DEPTH = MAX_PLANES * MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   logic [4:0] cfg_kw_ff, cfg_kh_ff, cfg_sx_ff, cfg_sy_ff;
   logic [3:0] cfg_px_ff, cfg_py_ff;
   logic [6:0] cfg_iw_ff, cfg_ih_ff;

   state_type     state_ff, state_in;
   logic [11:0]   k_ff, k_in;
   logic [5:0]    y_ff, y_in;
   logic [7:0]    out_w_m1_ff, out_w_m1_in;
   logic [7:0]    out_h_m1_ff, out_h_m1_in;
   logic [PW-1:0] pl_ff, pl_in;
   logic [4:0]    kh_ff, kh_in;
   logic [4:0]    kw_ff, kw_in;
   logic          row_ok_ff, row_ok_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [11:0]   ix_ff, ix_in;
   logic [5:0]    x_ff, x_in;

   logic          rsp_vld_ff, rsp_vld_in;
   logic          rsp_inb_ff, rsp_inb_in;
   logic [5:0]    rsp_col_ff, rsp_col_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_err_ff, rsp_err_in;

   div_req_type   div_req;
   div_rsp_type   div_rsp;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   logic [7:0]    span_w, span_h;
   logic [9:0]    area;
   logic          static_err;
   logic [11:0]   iy;
   logic          inb;
   logic          accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign span_w = 8'(cfg_iw_ff) + {3'b0, cfg_px_ff, 1'b0};
   assign span_h = 8'(cfg_ih_ff) + {3'b0, cfg_py_ff, 1'b0};
   assign area   = 10'({5'b0, cfg_kw_ff} * {5'b0, cfg_kh_ff});

   assign static_err = (cfg_kw_ff == '0) || (cfg_kh_ff == '0) ||
                       (cfg_sx_ff == '0) || (cfg_sy_ff == '0) ||
                       (cfg_iw_ff == '0) || (32'(cfg_iw_ff) > MAX_WIDTH) ||
                       (cfg_ih_ff == '0) || (32'(cfg_ih_ff) > MAX_HEIGHT) ||
                       (span_w < {3'b0, cfg_kw_ff}) || (span_h < {3'b0, cfg_kh_ff});

   assign iy  = 12'({6'b0, y_ff} * {7'b0, cfg_sy_ff}) + 12'(kh_ff) - 12'(cfg_py_ff);
   assign inb = row_ok_ff && !ix_ff[11] && (ix_ff[10:0] < 11'(cfg_iw_ff));

   // load path
   assign wr_en   = accept && (req_op == OP_LOAD) &&
                    (32'(req_plane) < MAX_PLANES) &&
                    (32'(req_pix_row) < MAX_HEIGHT) &&
                    (32'(req_pix_col) < MAX_WIDTH);
   assign wr_addr = AW'((32'(req_plane) * MAX_HEIGHT + 32'(req_pix_row)) * MAX_WIDTH
                        + 32'(req_pix_col));
   assign rd_addr = row_base_ff + AW'(ix_ff[10:0]);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      y_in        = y_ff;
      out_w_m1_in = out_w_m1_ff;
      out_h_m1_in = out_h_m1_ff;
      pl_in       = pl_ff;
      kh_in       = kh_ff;
      kw_in       = kw_ff;
      row_ok_in   = row_ok_ff;
      row_base_in = row_base_ff;
      ix_in       = ix_ff;
      x_in        = x_ff;
      rsp_vld_in  = 1'b0;
      rsp_inb_in  = 1'b0;
      rsp_col_in  = '0;
      rsp_last_in = 1'b0;
      rsp_err_in  = 1'b0;
      div_req     = '0;
      rd_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_EMIT)) begin
               k_in = req_unfold_row;
               y_in = req_out_row;
               if (static_err) begin
                  rsp_vld_in  = 1'b1;
                  rsp_last_in = 1'b1;
                  rsp_err_in  = 1'b1;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 12'(span_w - {3'b0, cfg_kw_ff});
                  div_req.divisor  = 10'(cfg_sx_ff);
                  state_in         = ST_DIVW;
               end
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               out_w_m1_in      = div_rsp.quot[7:0];
               div_req.start    = 1'b1;
               div_req.dividend = 12'(span_h - {3'b0, cfg_kh_ff});
               div_req.divisor  = 10'(cfg_sy_ff);
               state_in         = ST_DIVH;
            end
         end
         ST_DIVH: begin
            if (div_rsp.done) begin
               out_h_m1_in = div_rsp.quot[7:0];
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((out_w_m1_ff > 8'(SEG_LIMIT - 1)) || ({2'b0, y_ff} > out_h_m1_ff) ||
                (32'(k_ff) >= MAX_PLANES * 32'(area))) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               rsp_err_in  = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = k_ff;
               div_req.divisor  = area;
               state_in         = ST_DIVK;
            end
         end
         ST_DIVK: begin
            if (div_rsp.done) begin
               pl_in            = PW'(div_rsp.quot);
               div_req.start    = 1'b1;
               div_req.dividend = 12'(div_rsp.rem);
               div_req.divisor  = 10'(cfg_kw_ff);
               state_in         = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (div_rsp.done) begin
               kh_in    = div_rsp.quot[4:0];
               kw_in    = div_rsp.rem[4:0];
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            row_ok_in   = !iy[11] && (iy[10:0] < 11'(cfg_ih_ff));
            row_base_in = AW'((32'(pl_ff) * MAX_HEIGHT + 32'(iy[10:0])) * MAX_WIDTH);
            ix_in       = 12'(kw_ff) - 12'(cfg_px_ff);
            x_in        = '0;
            state_in    = ST_STREAM;
         end
         ST_STREAM: begin
            rd_en       = inb;
            rsp_vld_in  = 1'b1;
            rsp_inb_in  = inb;
            rsp_col_in  = x_ff;
            rsp_last_in = (x_ff == out_w_m1_ff[5:0]);
            x_in        = x_ff + 1'b1;
            ix_in       = ix_ff + 12'(cfg_sx_ff);
            if (x_ff == out_w_m1_ff[5:0]) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_vld_ff  <= 1'b0;
         rsp_inb_ff  <= 1'b0;
         rsp_col_ff  <= '0;
         rsp_last_ff <= 1'b0;
         rsp_err_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rsp_vld_ff  <= rsp_vld_in;
         rsp_inb_ff  <= rsp_inb_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_last_ff <= rsp_last_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      y_ff        <= y_in;
      out_w_m1_ff <= out_w_m1_in;
      out_h_m1_ff <= out_h_m1_in;
      pl_ff       <= pl_in;
      kh_ff       <= kh_in;
      kw_ff       <= kw_in;
      row_ok_ff   <= row_ok_in;
      row_base_ff <= row_base_in;
      ix_ff       <= ix_in;
      x_ff        <= x_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_kw_ff <= 5'd3;
         cfg_kh_ff <= 5'd3;
         cfg_sx_ff <= 5'd1;
         cfg_sy_ff <= 5'd1;
         cfg_px_ff <= 4'd0;
         cfg_py_ff <= 4'd0;
         cfg_iw_ff <= 7'd64;
         cfg_ih_ff <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            CFG_KERNEL_WIDTH:  cfg_kw_ff <= csr_wdata[4:0];
            CFG_KERNEL_HEIGHT: cfg_kh_ff <= csr_wdata[4:0];
            CFG_STRIDE_X:      cfg_sx_ff <= csr_wdata[4:0];
            CFG_STRIDE_Y:      cfg_sy_ff <= csr_wdata[4:0];
            CFG_PAD_X:         cfg_px_ff <= csr_wdata[3:0];
            CFG_PAD_Y:         cfg_py_ff <= csr_wdata[3:0];
            CFG_IMAGE_WIDTH:   cfg_iw_ff <= csr_wdata;
            CFG_IMAGE_HEIGHT:  cfg_ih_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   iue_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   iue_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_value   = rsp_inb_ff ? rd_data : 8'd0;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_error   = rsp_err_ff;

endmodule

>>> rtl/iue_checker.sv
// ----------------------------------------------------------------------------
// iue_checker
// port-level checks on the result beats of the unfold engine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iue_checker
   import iue_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_op,
   input logic       rsp_valid,
   input logic [7:0] rsp_value,
   input logic [5:0] rsp_out_col,
   input logic       rsp_last,
   input logic       rsp_error
);

   // error beat is a lone, zeroed, final beat
   `IUE_ASSERT_NOW(a_err_shape, clock, reset, rsp_valid && rsp_error, rsp_last && (rsp_value == 8'd0) && (rsp_out_col == 6'd0))

   // segment beats come back to back
   `IUE_ASSERT_NEXT(a_seg_contig, clock, reset, rsp_valid && !rsp_last, rsp_valid && !rsp_error)

   // columns count up by one within a segment
   `IUE_ASSERT_NEXT(a_col_step, clock, reset, rsp_valid && !rsp_last, rsp_out_col == 6'($past(rsp_out_col) + 6'd1))

   // mid-segment beats only while the engine is busy
   `IUE_ASSERT_NOW(a_busy_seg, clock, reset, rsp_valid && !rsp_last, busy)

   // a load never causes a result beat
   `IUE_ASSERT_NEXT(a_load_quiet, clock, reset, start && !busy && (req_op == OP_LOAD), !rsp_valid)

endmodule

bind im2col_unfold_engine iue_checker u_iue_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_value   (rsp_value),
   .rsp_out_col (rsp_out_col),
   .rsp_last    (rsp_last),
   .rsp_error   (rsp_error)
);
